@@ hdl/dss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the drum step sequencer: operation codes,
// controller/datapath command and status bundles, velocity constants.
// ----------------------------------------------------------------------------
package dss_pkg;

    typedef enum logic [3:0] {
        MODE_TICK   = 4'd0,
        MODE_START  = 4'd1,
        MODE_STOP   = 4'd2,
        MODE_SET    = 4'd3,
        MODE_TOGGLE = 4'd4,
        MODE_CYCLE  = 4'd5,
        MODE_CLEAR  = 4'd6,
        MODE_QWRITE = 4'd7,
        MODE_COMMIT = 4'd8,
        MODE_LENGTH = 4'd9,
        MODE_READ   = 4'd10
    } mode_t;

    localparam int MAX_RESULTS = 8;

    localparam logic [7:0] VEL_FULL    = 8'd255;
    localparam logic [7:0] VEL_HALF    = 8'd128;
    localparam logic [7:0] VEL_QUARTER = 8'd64;
    localparam logic [7:0] VEL_EIGHTH  = 8'd32;

    localparam logic [7:0] PPS_RESET = 8'd6;
    localparam logic [6:0] LEN_RESET = 7'd16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic tick_count;
        logic tick_step;
        logic do_start;
        logic do_stop;
        logic wr_set;
        logic wr_queue;
        logic rmw_write;
        logic commit;
        logic set_len;
        logic sweep_rst;
        logic clear_active;
        logic clear_queued;
        logic copy_step;
        logic scan_rst;
        logic scan_step;
        logic emit_status;
        logic emit_read;
        logic flush;
    } dss_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        mode_t mode;
        logic  addr_ok;
        logic  playing;
        logic  advance;
        logic  wrap_load;
        logic  clr_last;
        logic  copy_last;
        logic  pos_ok;
        logic  scan_end;
    } dss_status_t;

    // velocity cycle: off, full, half, quarter, eighth, off
    function automatic logic [7:0] cycle_next(input logic [7:0] v);
        logic [7:0] r;
        if (v == 8'd0)
            r = VEL_FULL;
        else if (v == VEL_FULL)
            r = VEL_HALF;
        else if (v == VEL_HALF)
            r = VEL_QUARTER;
        else if (v == VEL_QUARTER)
            r = VEL_EIGHTH;
        else
            r = 8'd0;
        return r;
    endfunction

endpackage

@@ hdl/dss_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ctrl
// Controller of the drum step sequencer: decodes each accepted command and
// sequences the datapath through edits, memory sweeps and the trigger scan.
// ----------------------------------------------------------------------------
module dss_ctrl
    import dss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  dss_status_t status,
    output dss_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_RMW,
        S_RDWAIT,
        S_CLEAR,
        S_COPY,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                // power-up pass zeroes both stores
                cmd.clear_active = 1'b1;
                cmd.clear_queued = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (status.mode)
                    MODE_TICK:
                    begin
                        if (!status.playing)
                            cmd.emit_status = 1'b1;
                        else if (!status.advance)
                        begin
                            cmd.tick_count  = 1'b1;
                            cmd.emit_status = 1'b1;
                        end
                        else
                        begin
                            cmd.tick_step = 1'b1;
                            if (status.wrap_load)
                            begin
                                cmd.sweep_rst = 1'b1;
                                state_next    = S_COPY;
                            end
                            else
                            begin
                                cmd.scan_rst = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                    end
                    MODE_START:
                    begin
                        cmd.do_start = 1'b1;
                        cmd.scan_rst = 1'b1;
                        state_next   = S_SCAN;
                    end
                    MODE_STOP:
                    begin
                        cmd.do_stop     = 1'b1;
                        cmd.emit_status = 1'b1;
                    end
                    MODE_SET:
                    begin
                        cmd.wr_set      = 1'b1;
                        cmd.emit_status = 1'b1;
                    end
                    MODE_TOGGLE, MODE_CYCLE:
                    begin
                        if (status.addr_ok)
                            state_next = S_RMW;
                        else
                            cmd.emit_status = 1'b1;
                    end
                    MODE_CLEAR:
                    begin
                        cmd.sweep_rst = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    MODE_QWRITE:
                    begin
                        cmd.wr_queue    = 1'b1;
                        cmd.emit_status = 1'b1;
                    end
                    MODE_COMMIT:
                    begin
                        cmd.commit      = 1'b1;
                        cmd.emit_status = 1'b1;
                    end
                    MODE_LENGTH:
                    begin
                        cmd.set_len     = 1'b1;
                        cmd.emit_status = 1'b1;
                    end
                    MODE_READ:
                    begin
                        if (status.addr_ok)
                            state_next = S_RDWAIT;
                        else
                            cmd.emit_status = 1'b1;
                    end
                    default:
                    begin
                        cmd.emit_status = 1'b1;
                    end
                endcase
            end
            S_RMW:
            begin
                cmd.rmw_write   = 1'b1;
                cmd.emit_status = 1'b1;
                state_next      = S_IDLE;
            end
            S_RDWAIT:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.clear_active = 1'b1;
                if (status.clr_last)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    cmd.scan_rst = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!status.pos_ok)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_end)
                        state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

@@ hdl/dss_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_datapath
// Datapath of the drum step sequencer: active and queued velocity memories,
// transport state, sweep and scan counters, and the result register.
// ----------------------------------------------------------------------------
module dss_datapath
    import dss_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int STEPS    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  dss_cmd_t    cmd,
    output dss_status_t status,
    input  logic [3:0]  mode,
    input  logic [2:0]  channel,
    input  logic [5:0]  step,
    input  logic [7:0]  value,
    input  logic [6:0]  count,
    input  logic [7:0]  slot,
    output logic        strobe,
    output logic        trigger_valid,
    output logic [2:0]  trigger_channel,
    output logic [7:0]  trigger_velocity,
    output logic        last,
    output logic [7:0]  read_value,
    output logic [5:0]  position,
    output logic        running,
    output logic        queue_pending,
    output logic [7:0]  pending_slot
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW    = CW + SW;
    localparam int AW1   = AW + 1;
    localparam int DEPTH = 1 << AW;
    localparam int KW    = $clog2(CHANNELS + 1);

    localparam logic [4:0]    CH_LIMIT   = 5'(CHANNELS);
    localparam logic [6:0]    STEP_LIMIT = 7'(STEPS);
    localparam logic [KW-1:0] K_LAST     = KW'(CHANNELS);
    localparam logic [AW:0]   SWEEP_LAST = AW1'(DEPTH - 1);
    localparam logic [AW:0]   SWEEP_END  = AW1'(DEPTH);
    localparam logic [3:0]    FOUND_CAP  = 4'(MAX_RESULTS - 1);

    // latched command fields
    logic [3:0] mode_q;
    logic [2:0] chan_q;
    logic [5:0] step_q;
    logic [7:0] value_q;
    logic [6:0] count_q;
    logic [7:0] slot_q;

    // transport state
    logic [7:0] pps_reg;
    logic [7:0] pulse_reg;
    logic [5:0] pos_reg;
    logic [6:0] alen_reg;
    logic [6:0] qlen_reg;
    logic       play_reg;
    logic       pend_reg;
    logic [7:0] slot_reg;

    // velocity stores
    logic [7:0] act_mem [DEPTH];
    logic [7:0] que_mem [DEPTH];
    logic [7:0] act_rd_reg;
    logic [7:0] que_rd_reg;

    // sweep and scan
    logic [AW:0]   sweep_reg;
    logic [KW-1:0] scan_k_reg;
    logic [3:0]    found_reg;
    logic          hold_valid_reg;
    logic [2:0]    hold_ch_reg;
    logic [7:0]    hold_vel_reg;

    // result register
    logic       strobe_reg;
    logic       tv_reg;
    logic [2:0] tch_reg;
    logic [7:0] tvel_reg;
    logic       last_reg;
    logic [7:0] rd_reg;

    logic          addr_ok;
    logic [AW-1:0] edit_addr;
    logic [8:0]    pc;
    logic          advance;
    logic [6:0]    pos_inc;
    logic          wrap;
    logic [6:0]    wrap_len;
    logic          pos_ok;
    logic          hit;
    logic          scan_end;
    logic [KW-1:0] exam_ch;
    logic [AW:0]   sweep_dec;
    logic [AW-1:0] act_raddr;
    logic          act_we;
    logic [AW-1:0] act_waddr;
    logic [7:0]    act_wdata;
    logic          que_we;
    logic [AW-1:0] que_waddr;
    logic [7:0]    que_wdata;
    logic [7:0]    rmw_value;

    assign addr_ok   = ({2'b00, chan_q} < CH_LIMIT) && ({1'b0, step_q} < STEP_LIMIT);
    assign edit_addr = {CW'(chan_q), SW'(step_q)};

    assign pc      = {1'b0, pulse_reg} + 9'd1;
    assign advance = (pc >= {1'b0, pps_reg});   // zero pulses per step acts as one
    assign pos_inc = {1'b0, pos_reg} + 7'd1;
    assign wrap    = (pos_inc >= alen_reg);
    assign pos_ok  = ({1'b0, pos_reg} < STEP_LIMIT);

    always_comb
    begin
        priority if (qlen_reg == 7'd0)
            wrap_len = 7'd1;
        else if (qlen_reg > STEP_LIMIT)
            wrap_len = STEP_LIMIT;
        else
            wrap_len = qlen_reg;
    end

    // scan looks at the read data of the previous channel address
    assign exam_ch  = scan_k_reg - KW'(1);
    assign hit      = (scan_k_reg != '0) && (act_rd_reg != 8'd0);
    assign scan_end = (scan_k_reg == K_LAST) || (hit && (found_reg == FOUND_CAP));

    assign sweep_dec = sweep_reg - AW1'(1);

    assign act_raddr = cmd.scan_step ? {CW'(scan_k_reg), SW'(pos_reg)} : edit_addr;
    assign rmw_value = (mode_t'(mode_q) == MODE_TOGGLE) ?
                       ((act_rd_reg == 8'd0) ? VEL_FULL : 8'd0) : cycle_next(act_rd_reg);

    always_comb
    begin
        act_we    = 1'b0;
        act_waddr = edit_addr;
        act_wdata = value_q;
        priority if (cmd.clear_active)
        begin
            act_we    = 1'b1;
            act_waddr = sweep_reg[AW-1:0];
            act_wdata = 8'd0;
        end
        else if (cmd.copy_step && (sweep_reg != '0))
        begin
            act_we    = 1'b1;
            act_waddr = sweep_dec[AW-1:0];
            act_wdata = que_rd_reg;
        end
        else if (cmd.wr_set && addr_ok)
        begin
            act_we = 1'b1;
        end
        else if (cmd.rmw_write)
        begin
            act_we    = 1'b1;
            act_wdata = rmw_value;
        end
    end

    assign que_we    = cmd.clear_queued || (cmd.wr_queue && addr_ok);
    assign que_waddr = cmd.clear_queued ? sweep_reg[AW-1:0] : edit_addr;
    assign que_wdata = cmd.clear_queued ? 8'd0 : value_q;

    always_ff @(posedge clk)
    begin
        if (act_we)
            act_mem[act_waddr] <= act_wdata;
        act_rd_reg <= act_mem[act_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (que_we)
            que_mem[que_waddr] <= que_wdata;
        que_rd_reg <= que_mem[sweep_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_q  <= mode;
            chan_q  <= channel;
            step_q  <= step;
            value_q <= value;
            count_q <= count;
            slot_q  <= slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pps_reg   <= PPS_RESET;
            pulse_reg <= 8'd0;
            pos_reg   <= 6'd0;
            alen_reg  <= LEN_RESET;
            qlen_reg  <= 7'd0;
            play_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            slot_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_we)
                pps_reg <= cfg_data;
            if (cmd.tick_count)
                pulse_reg <= pc[7:0];
            if (cmd.tick_step)
            begin
                pulse_reg <= 8'd0;
                if (wrap)
                begin
                    pos_reg <= 6'd0;
                    if (pend_reg)
                    begin
                        alen_reg <= wrap_len;
                        pend_reg <= 1'b0;
                    end
                end
                else
                    pos_reg <= pos_inc[5:0];
            end
            if (cmd.do_start)
            begin
                pos_reg   <= 6'd0;
                pulse_reg <= 8'd0;
                play_reg  <= 1'b1;
            end
            if (cmd.do_stop)
            begin
                pos_reg   <= 6'd0;
                pulse_reg <= 8'd0;
                play_reg  <= 1'b0;
            end
            if (cmd.commit)
            begin
                qlen_reg <= count_q;
                slot_reg <= slot_q;
                pend_reg <= 1'b1;
            end
            if (cmd.set_len && (count_q >= 7'd1) && (count_q <= STEP_LIMIT))
                alen_reg <= count_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg      <= '0;
            scan_k_reg     <= '0;
            found_reg      <= 4'd0;
            hold_valid_reg <= 1'b0;
            hold_ch_reg    <= 3'd0;
            hold_vel_reg   <= 8'd0;
        end
        else
        begin
            if (cmd.sweep_rst)
                sweep_reg <= '0;
            else if (cmd.clear_active || cmd.clear_queued || cmd.copy_step)
                sweep_reg <= sweep_reg + AW1'(1);

            if (cmd.scan_rst)
            begin
                scan_k_reg     <= '0;
                found_reg      <= 4'd0;
                hold_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_k_reg <= scan_k_reg + KW'(1);
                if (hit)
                begin
                    hold_valid_reg <= 1'b1;
                    hold_ch_reg    <= 3'(exam_ch);
                    hold_vel_reg   <= act_rd_reg;
                    found_reg      <= found_reg + 4'd1;
                end
            end
        end
    end

    // a trigger is held back one hit so the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            tv_reg     <= 1'b0;
            tch_reg    <= 3'd0;
            tvel_reg   <= 8'd0;
            last_reg   <= 1'b0;
            rd_reg     <= 8'd0;
        end
        else
        begin
            priority if (cmd.emit_status || cmd.emit_read)
            begin
                strobe_reg <= 1'b1;
                tv_reg     <= 1'b0;
                tch_reg    <= 3'd0;
                tvel_reg   <= 8'd0;
                last_reg   <= 1'b1;
                rd_reg     <= cmd.emit_read ? act_rd_reg : 8'd0;
            end
            else if (cmd.scan_step && hit && hold_valid_reg)
            begin
                strobe_reg <= 1'b1;
                tv_reg     <= 1'b1;
                tch_reg    <= hold_ch_reg;
                tvel_reg   <= hold_vel_reg;
                last_reg   <= 1'b0;
                rd_reg     <= 8'd0;
            end
            else if (cmd.flush)
            begin
                strobe_reg <= 1'b1;
                tv_reg     <= hold_valid_reg;
                tch_reg    <= hold_valid_reg ? hold_ch_reg : 3'd0;
                tvel_reg   <= hold_valid_reg ? hold_vel_reg : 8'd0;
                last_reg   <= 1'b1;
                rd_reg     <= 8'd0;
            end
            else
                strobe_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.mode      = mode_t'(mode_q);
        status.addr_ok   = addr_ok;
        status.playing   = play_reg;
        status.advance   = advance;
        status.wrap_load = wrap && pend_reg;
        status.clr_last  = (sweep_reg == SWEEP_LAST);
        status.copy_last = (sweep_reg == SWEEP_END);
        status.pos_ok    = pos_ok;
        status.scan_end  = scan_end;
    end

    assign strobe           = strobe_reg;
    assign trigger_valid    = tv_reg;
    assign trigger_channel  = tch_reg;
    assign trigger_velocity = tvel_reg;
    assign last             = last_reg;
    assign read_value       = rd_reg;
    assign position         = pos_reg;
    assign running          = play_reg;
    assign queue_pending    = pend_reg;
    assign pending_slot     = slot_reg;

endmodule

@@ hdl/drum_step_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_step_sequencer_unit
// Drum step sequencer with active and queued velocity patterns, tick-driven
// transport, pattern edits and queued pattern swap at the loop point.
//
// channel   signals                                     handshake
// command   start, busy, mode..slot                     start & !busy
// result    strobe, trigger_*, last, read_value, status strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_data              cfg_valid & cfg_ready
//
// edits, stop, commit, length, plain ticks: result strobed as busy falls
// toggle, cycle, read: via S_RMW or S_RDWAIT (read-modify-write on act_mem)
// step fire: one channel read per cycle from the memory port
// loop wrap with a queued pattern: a copy sweep of 2^AW addresses comes first
// clear: a 2^AW sweep zeroes the active memory; reset zeroes both memories
// (2^AW is 512 at defaults); results are never stalled by the receiver
// ----------------------------------------------------------------------------
module drum_step_sequencer_unit
    import dss_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int STEPS    = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] mode,
    input  logic [2:0] channel,
    input  logic [5:0] step,
    input  logic [7:0] value,
    input  logic [6:0] count,
    input  logic [7:0] slot,
    output logic       strobe,
    output logic       trigger_valid,
    output logic [2:0] trigger_channel,
    output logic [7:0] trigger_velocity,
    output logic       last,
    output logic [7:0] read_value,
    output logic [5:0] position,
    output logic       running,
    output logic       queue_pending,
    output logic [7:0] pending_slot,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    dss_cmd_t    cmd;
    dss_status_t status;

    // the register is taken on any cycle
    assign cfg_ready = 1'b1;

    dss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    dss_datapath #(
        .CHANNELS (CHANNELS),
        .STEPS    (STEPS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .mode             (mode),
        .channel          (channel),
        .step             (step),
        .value            (value),
        .count            (count),
        .slot             (slot),
        .strobe           (strobe),
        .trigger_valid    (trigger_valid),
        .trigger_channel  (trigger_channel),
        .trigger_velocity (trigger_velocity),
        .last             (last),
        .read_value       (read_value),
        .position         (position),
        .running          (running),
        .queue_pending    (queue_pending),
        .pending_slot     (pending_slot)
    );

endmodule

@@ hdl/dss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks of the drum step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       trigger_valid,
    input logic [7:0] trigger_velocity,
    input logic       last,
    input logic [7:0] read_value,
    input logic [5:0] position,
    input logic       running
);

    // a fired channel always has a nonzero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && trigger_valid |-> trigger_velocity != 8'd0)
        else $error("trigger with zero velocity");

    // a result that fires nothing is the only result of its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !trigger_valid |-> last)
        else $error("status result without last");

    // read data only rides on a status result
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (read_value != 8'd0) |-> !trigger_valid && last)
        else $error("read data on a trigger result");

    // an accepted command keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command transfer");

    // stopped transport sits at step zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !running |-> position == 6'd0)
        else $error("position moved while stopped");

endmodule

bind drum_step_sequencer_unit dss_checker u_dss_checker (.*);
